FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Types, constants and step functions of the triangle offset and normal core.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_W   = 32;
    localparam int NRM_W     = 16;
    localparam int EDGE_W    = 33;
    localparam int PROD_W    = 66;
    localparam int MAG_W     = 65;
    localparam int LEN_W     = 7;
    localparam int S_W       = 30;
    localparam int SQ_W      = 60;
    localparam int SUM_W     = 62;
    localparam int ROOT_W    = 31;
    localparam int REM_W     = 33;
    localparam int DREM_W    = 31;
    localparam int NVTX      = 9;
    localparam int NAXIS     = 3;
    localparam int FRONT_LAT = 7;
    localparam int NORM_FRAC_BITS = 14;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 2'd0,
        REG_OFFSET_Y = 2'd1,
        REG_OFFSET_Z = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_step;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic              bit_q;
    } t_div_step;

    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return s[COORD_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] v);
        logic [LEN_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                m = LEN_W'(i + 1);
            end
        end
        return m;
    endfunction

    function automatic t_sqrt_step sqrt_step(input logic [REM_W-1:0] rem,
                                             input logic [ROOT_W-1:0] root,
                                             input logic [1:0] pair);
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        t_sqrt_step       r;
        t     = {rem, pair};
        trial = (REM_W+2)'({root, 2'b01});
        if (t >= trial) begin
            r.rem  = REM_W'(t - trial);
            r.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = REM_W'(t);
            r.root = {root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_div_step div_step(input logic [DREM_W-1:0] rem,
                                           input logic nbit,
                                           input logic [ROOT_W-1:0] len);
        logic [DREM_W:0] t;
        t_div_step       r;
        t = {rem, nbit};
        if (t >= (DREM_W+1)'(len)) begin
            r.rem   = DREM_W'(t - (DREM_W+1)'(len));
            r.bit_q = 1'b1;
        end else begin
            r.rem   = DREM_W'(t);
            r.bit_q = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: rtl/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front
// Offset add, edges, cross product, scaling to 30 bits and sum of squares.
// ----------------------------------------------------------------------------
module tfn_front (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_vld,
    input  logic [tfn_pkg::NVTX-1:0][tfn_pkg::COORD_W-1:0]    i_vtx,
    input  logic [tfn_pkg::NAXIS-1:0][tfn_pkg::COORD_W-1:0]   i_off,
    output logic                                              o_vld,
    output logic [tfn_pkg::NVTX-1:0][tfn_pkg::COORD_W-1:0]    o_moved,
    output logic [tfn_pkg::NAXIS-1:0]                         o_neg,
    output logic                                              o_zero,
    output logic [tfn_pkg::NAXIS-1:0][tfn_pkg::S_W-1:0]       o_s,
    output logic [tfn_pkg::SUM_W-1:0]                         o_sum
);

    localparam int L = tfn_pkg::FRONT_LAT;

    logic [L:1]                                           r_vld;
    logic [tfn_pkg::NVTX-1:0][tfn_pkg::COORD_W-1:0]       r_moved [1:L];
    logic signed [tfn_pkg::EDGE_W-1:0]                    r_e1 [3];
    logic signed [tfn_pkg::EDGE_W-1:0]                    r_e2 [3];
    logic signed [tfn_pkg::PROD_W-1:0]                    r_p [6];
    logic [tfn_pkg::MAG_W-1:0]                            r_mag [3];
    logic [tfn_pkg::MAG_W-1:0]                            r_mag_d [3];
    logic [tfn_pkg::NAXIS-1:0]                            r_neg [3:L];
    logic [tfn_pkg::LEN_W-1:0]                            r_m;
    logic                                                 r_zero [4:L];
    logic [tfn_pkg::NAXIS-1:0][tfn_pkg::S_W-1:0]          r_s [5:L];
    logic [tfn_pkg::SQ_W-1:0]                             r_sq [3];
    logic [tfn_pkg::SUM_W-1:0]                            r_sum;

    logic signed [tfn_pkg::PROD_W-1:0]                    n_d [3];
    logic [tfn_pkg::MAG_W-1:0]                            n_mag [3];
    logic [tfn_pkg::NAXIS-1:0][tfn_pkg::S_W-1:0]          n_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i]   = r_p[2*i] - r_p[2*i+1];
            n_mag[i] = n_d[i][tfn_pkg::PROD_W-1] ? tfn_pkg::MAG_W'(-n_d[i])
                                                  : tfn_pkg::MAG_W'(n_d[i]);
            if (r_m >= tfn_pkg::LEN_W'(tfn_pkg::S_W)) begin
                n_s[i] = tfn_pkg::S_W'(r_mag_d[i] >> (r_m - tfn_pkg::LEN_W'(tfn_pkg::S_W)));
            end else begin
                n_s[i] = tfn_pkg::S_W'(r_mag_d[i] << (tfn_pkg::LEN_W'(tfn_pkg::S_W) - r_m));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[L-1:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tfn_pkg::NVTX; i++) begin
            r_moved[1][i] <= tfn_pkg::sat_add(i_vtx[i], i_off[i % 3]);
        end
        for (int k = 2; k <= L; k++) begin
            r_moved[k] <= r_moved[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_e1[i] <= {i_vtx[3+i][tfn_pkg::COORD_W-1], i_vtx[3+i]}
                     - {i_vtx[i][tfn_pkg::COORD_W-1], i_vtx[i]};
            r_e2[i] <= {i_vtx[6+i][tfn_pkg::COORD_W-1], i_vtx[6+i]}
                     - {i_vtx[i][tfn_pkg::COORD_W-1], i_vtx[i]};
        end
        r_p[0] <= r_e2[1] * r_e1[2];
        r_p[1] <= r_e1[1] * r_e2[2];
        r_p[2] <= r_e2[2] * r_e1[0];
        r_p[3] <= r_e1[2] * r_e2[0];
        r_p[4] <= r_e2[0] * r_e1[1];
        r_p[5] <= r_e1[0] * r_e2[1];
        for (int i = 0; i < 3; i++) begin
            r_mag[i]    <= n_mag[i];
            r_mag_d[i]  <= r_mag[i];
            r_neg[3][i] <= n_d[i][tfn_pkg::PROD_W-1];
        end
        for (int k = 4; k <= L; k++) begin
            r_neg[k] <= r_neg[k-1];
        end
        r_m       <= tfn_pkg::bit_len(r_mag[0] | r_mag[1] | r_mag[2]);
        r_zero[4] <= ~|(r_mag[0] | r_mag[1] | r_mag[2]);
        for (int k = 5; k <= L; k++) begin
            r_zero[k] <= r_zero[k-1];
        end
        r_s[5] <= n_s;
        for (int k = 6; k <= L; k++) begin
            r_s[k] <= r_s[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= tfn_pkg::SQ_W'(r_s[5][i] * r_s[5][i]);
        end
        r_sum <= tfn_pkg::SUM_W'(r_sq[0]) + tfn_pkg::SUM_W'(r_sq[1])
               + tfn_pkg::SUM_W'(r_sq[2]);
    end

    assign o_vld   = r_vld[L];
    assign o_moved = r_moved[L];
    assign o_neg   = r_neg[L];
    assign o_zero  = r_zero[L];
    assign o_s     = r_s[L];
    assign o_sum   = r_sum;

endmodule

FILE: rtl/tfn_isqrt.sv
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one result bit per stage, side word carried.
// ----------------------------------------------------------------------------
module tfn_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [tfn_pkg::SUM_W-1:0]     i_x,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_vld,
    output logic [tfn_pkg::ROOT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int N = tfn_pkg::ROOT_W;

    logic [N:1]                        r_vld;
    logic [tfn_pkg::SUM_W-1:0]         r_x    [1:N];
    logic [tfn_pkg::REM_W-1:0]         r_rem  [1:N];
    logic [tfn_pkg::ROOT_W-1:0]        r_root [1:N];
    logic [SIDE_W-1:0]                 r_side [1:N];
    tfn_pkg::t_sqrt_step               n_st   [1:N];

    always_comb begin
        n_st[1] = tfn_pkg::sqrt_step('0, '0, i_x[tfn_pkg::SUM_W-1 -: 2]);
        for (int k = 2; k <= N; k++) begin
            n_st[k] = tfn_pkg::sqrt_step(r_rem[k-1], r_root[k-1],
                                         r_x[k-1][tfn_pkg::SUM_W-1 -: 2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-1:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[1]    <= i_x << 2;
        r_side[1] <= i_side;
        for (int k = 2; k <= N; k++) begin
            r_x[k]    <= r_x[k-1] << 2;
            r_side[k] <= r_side[k-1];
        end
        for (int k = 1; k <= N; k++) begin
            r_rem[k]  <= n_st[k].rem;
            r_root[k] <= n_st[k].root;
        end
    end

    assign o_vld  = r_vld[N];
    assign o_root = r_root[N];
    assign o_side = r_side[N];

endmodule

FILE: rtl/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div
// Three-lane pipelined rounding divider by the length, clamp and sign restore.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfn_div #(
    parameter int P_FRAC = tfn_pkg::NORM_FRAC_BITS,
    parameter int SIDE_W = 1
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_vld,
    input  logic [tfn_pkg::ROOT_W-1:0]                    i_len,
    input  logic [tfn_pkg::NAXIS-1:0][tfn_pkg::S_W-1:0]   i_s,
    input  logic [tfn_pkg::NAXIS-1:0]                     i_neg,
    input  logic                                          i_zero,
    input  logic [SIDE_W-1:0]                             i_side,
    output logic                                          o_vld,
    output logic [tfn_pkg::NAXIS-1:0][tfn_pkg::NRM_W-1:0] o_nrm,
    output logic [SIDE_W-1:0]                             o_side
);

    localparam int QW = P_FRAC + 3;
    localparam int NW = tfn_pkg::S_W + P_FRAC + 1;
    localparam int N  = QW + 1;

    logic [N:0]                                  r_vld;
    logic [tfn_pkg::ROOT_W-1:0]                  r_len  [0:N-1];
    logic [tfn_pkg::NAXIS-1:0]                   r_neg  [0:N-1];
    logic                                        r_zero [0:N-1];
    logic [SIDE_W-1:0]                           r_side [0:N];
    logic [tfn_pkg::NAXIS-1:0][tfn_pkg::DREM_W-1:0] r_rem [0:N-1];
    logic [tfn_pkg::NAXIS-1:0][QW-1:0]           r_nlo  [0:N-1];
    logic [tfn_pkg::NAXIS-1:0][QW-1:0]           r_q    [0:N-1];
    logic [tfn_pkg::NAXIS-1:0][tfn_pkg::NRM_W-1:0] r_nrm;

    logic [tfn_pkg::NAXIS-1:0][NW-1:0]           n_num;
    tfn_pkg::t_div_step                          n_st [1:N-1][tfn_pkg::NAXIS];
    logic [QW-1:0]                               n_qc [tfn_pkg::NAXIS];
    logic [QW+tfn_pkg::NRM_W-1:0]                n_qx [tfn_pkg::NAXIS];

    always_comb begin
        for (int i = 0; i < tfn_pkg::NAXIS; i++) begin
            n_num[i] = {1'b0, i_s[i], {P_FRAC{1'b0}}} + NW'(i_len >> 1);
        end
        for (int k = 1; k < N; k++) begin
            for (int i = 0; i < tfn_pkg::NAXIS; i++) begin
                n_st[k][i] = tfn_pkg::div_step(r_rem[k-1][i], r_nlo[k-1][i][QW-1],
                                               r_len[k-1]);
            end
        end
        for (int i = 0; i < tfn_pkg::NAXIS; i++) begin
            n_qc[i] = (r_q[N-1][i] > (QW'(1) << P_FRAC)) ? (QW'(1) << P_FRAC)
                                                         : r_q[N-1][i];
            n_qx[i] = (QW+tfn_pkg::NRM_W)'(n_qc[i]);
            if (r_neg[N-1][i]) begin
                n_qx[i] = -n_qx[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_len[0]  <= i_len;
        r_neg[0]  <= i_neg;
        r_zero[0] <= i_zero;
        r_side[0] <= i_side;
        for (int i = 0; i < tfn_pkg::NAXIS; i++) begin
            r_rem[0][i] <= tfn_pkg::DREM_W'(n_num[i] >> QW);
            r_nlo[0][i] <= n_num[i][QW-1:0];
            r_q[0][i]   <= '0;
        end
        for (int k = 1; k < N; k++) begin
            r_len[k]  <= r_len[k-1];
            r_neg[k]  <= r_neg[k-1];
            r_zero[k] <= r_zero[k-1];
            r_side[k] <= r_side[k-1];
            for (int i = 0; i < tfn_pkg::NAXIS; i++) begin
                r_rem[k][i] <= n_st[k][i].rem;
                r_nlo[k][i] <= r_nlo[k-1][i] << 1;
                r_q[k][i]   <= {r_q[k-1][i][QW-2:0], n_st[k][i].bit_q};
            end
        end
        r_side[N] <= r_side[N-1];
        for (int i = 0; i < tfn_pkg::NAXIS; i++) begin
            r_nrm[i] <= r_zero[N-1] ? '0 : n_qx[i][tfn_pkg::NRM_W-1:0];
        end
    end

    assign o_vld  = r_vld[N];
    assign o_nrm  = r_nrm;
    assign o_side = r_side[N];

    `ASSERT_IMPLY(a_len_norm, i_clk, i_rst_n, i_vld && !i_zero,
        i_len[tfn_pkg::ROOT_W-1:tfn_pkg::ROOT_W-2] != 2'b00, "length below 2^29")
    `ASSERT_IMPLY(a_len_zero, i_clk, i_rst_n, i_vld && i_zero,
        i_len == '0 && i_s == '0, "degenerate item with nonzero length")

endmodule

FILE: rtl/triangle_offset_and_face_normal_core.sv
// ----------------------------------------------------------------------------
// triangle_offset_and_face_normal_core
// Moves a triangle by the offset registers and returns its unit face normal.
//
//   channel  | handshake        | words
//   ---------+------------------+-----------------------------------------
//   command  | start / busy     | i_a_* i_b_* i_c_* vertex coordinates
//   config   | i_cfg_we         | i_cfg_idx, i_cfg_data offset registers
//   result   | o_valid strobe   | o_moved_* coordinates, o_normal_*
//
// One word accepted every cycle; busy is never raised.
// The pipeline has 7 front stages, 31 square root stages and
// P_NORM_FRAC + 5 divider stages.
// Synchronous active-low reset clears the offsets and all valid bits.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_offset_and_face_normal_core #(
    parameter int P_NORM_FRAC = tfn_pkg::NORM_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [tfn_pkg::COORD_W-1:0] i_a_x,
    input  logic signed [tfn_pkg::COORD_W-1:0] i_a_y,
    input  logic signed [tfn_pkg::COORD_W-1:0] i_a_z,
    input  logic signed [tfn_pkg::COORD_W-1:0] i_b_x,
    input  logic signed [tfn_pkg::COORD_W-1:0] i_b_y,
    input  logic signed [tfn_pkg::COORD_W-1:0] i_b_z,
    input  logic signed [tfn_pkg::COORD_W-1:0] i_c_x,
    input  logic signed [tfn_pkg::COORD_W-1:0] i_c_y,
    input  logic signed [tfn_pkg::COORD_W-1:0] i_c_z,
    input  logic                              i_cfg_we,
    input  logic [tfn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tfn_pkg::COORD_W-1:0]       i_cfg_data,
    output logic                              o_valid,
    output logic signed [tfn_pkg::COORD_W-1:0] o_moved_a_x,
    output logic signed [tfn_pkg::COORD_W-1:0] o_moved_a_y,
    output logic signed [tfn_pkg::COORD_W-1:0] o_moved_a_z,
    output logic signed [tfn_pkg::COORD_W-1:0] o_moved_b_x,
    output logic signed [tfn_pkg::COORD_W-1:0] o_moved_b_y,
    output logic signed [tfn_pkg::COORD_W-1:0] o_moved_b_z,
    output logic signed [tfn_pkg::COORD_W-1:0] o_moved_c_x,
    output logic signed [tfn_pkg::COORD_W-1:0] o_moved_c_y,
    output logic signed [tfn_pkg::COORD_W-1:0] o_moved_c_z,
    output logic signed [tfn_pkg::NRM_W-1:0]   o_normal_x,
    output logic signed [tfn_pkg::NRM_W-1:0]   o_normal_y,
    output logic signed [tfn_pkg::NRM_W-1:0]   o_normal_z
);

    localparam int MOV_W  = tfn_pkg::NVTX * tfn_pkg::COORD_W;
    localparam int SQ_SIDE_W = MOV_W + tfn_pkg::NAXIS + 1 + tfn_pkg::NAXIS * tfn_pkg::S_W;
    localparam int LAT    = tfn_pkg::FRONT_LAT + tfn_pkg::ROOT_W + P_NORM_FRAC + 5;

    logic [tfn_pkg::NAXIS-1:0][tfn_pkg::COORD_W-1:0]    r_off;
    logic [tfn_pkg::NVTX-1:0][tfn_pkg::COORD_W-1:0]     w_vtx;

    logic                                                w_f_vld;
    logic [tfn_pkg::NVTX-1:0][tfn_pkg::COORD_W-1:0]     w_f_moved;
    logic [tfn_pkg::NAXIS-1:0]                           w_f_neg;
    logic                                                w_f_zero;
    logic [tfn_pkg::NAXIS-1:0][tfn_pkg::S_W-1:0]        w_f_s;
    logic [tfn_pkg::SUM_W-1:0]                           w_f_sum;

    logic                                                w_q_vld;
    logic [tfn_pkg::ROOT_W-1:0]                          w_q_len;
    logic [SQ_SIDE_W-1:0]                                w_q_side;
    logic [tfn_pkg::NVTX-1:0][tfn_pkg::COORD_W-1:0]     w_q_moved;
    logic [tfn_pkg::NAXIS-1:0]                           w_q_neg;
    logic                                                w_q_zero;
    logic [tfn_pkg::NAXIS-1:0][tfn_pkg::S_W-1:0]        w_q_s;

    logic [tfn_pkg::NVTX-1:0][tfn_pkg::COORD_W-1:0]     w_d_moved;
    logic [tfn_pkg::NAXIS-1:0][tfn_pkg::NRM_W-1:0]      w_d_nrm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
        end else if (i_cfg_we) begin
            case (tfn_pkg::t_reg_idx'(i_cfg_idx))
                tfn_pkg::REG_OFFSET_X: r_off[0] <= i_cfg_data;
                tfn_pkg::REG_OFFSET_Y: r_off[1] <= i_cfg_data;
                tfn_pkg::REG_OFFSET_Z: r_off[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy  = 1'b0;
    assign w_vtx = {i_c_z, i_c_y, i_c_x, i_b_z, i_b_y, i_b_x, i_a_z, i_a_y, i_a_x};

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_vtx   (w_vtx),
        .i_off   (r_off),
        .o_vld   (w_f_vld),
        .o_moved (w_f_moved),
        .o_neg   (w_f_neg),
        .o_zero  (w_f_zero),
        .o_s     (w_f_s),
        .o_sum   (w_f_sum)
    );

    tfn_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_f_vld),
        .i_x     (w_f_sum),
        .i_side  ({w_f_moved, w_f_neg, w_f_zero, w_f_s}),
        .o_vld   (w_q_vld),
        .o_root  (w_q_len),
        .o_side  (w_q_side)
    );

    assign {w_q_moved, w_q_neg, w_q_zero, w_q_s} = w_q_side;

    tfn_div #(
        .P_FRAC (P_NORM_FRAC),
        .SIDE_W (MOV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_q_vld),
        .i_len   (w_q_len),
        .i_s     (w_q_s),
        .i_neg   (w_q_neg),
        .i_zero  (w_q_zero),
        .i_side  (w_q_moved),
        .o_vld   (o_valid),
        .o_nrm   (w_d_nrm),
        .o_side  (w_d_moved)
    );

    assign o_moved_a_x = w_d_moved[0];
    assign o_moved_a_y = w_d_moved[1];
    assign o_moved_a_z = w_d_moved[2];
    assign o_moved_b_x = w_d_moved[3];
    assign o_moved_b_y = w_d_moved[4];
    assign o_moved_b_z = w_d_moved[5];
    assign o_moved_c_x = w_d_moved[6];
    assign o_moved_c_y = w_d_moved[7];
    assign o_moved_c_z = w_d_moved[8];
    assign o_normal_x  = w_d_nrm[0];
    assign o_normal_y  = w_d_nrm[1];
    assign o_normal_z  = w_d_nrm[2];

    `ASSERT_IMPLY(a_out_lat, i_clk, i_rst_n, o_valid, $past(start, LAT),
        "result without a matching start")

endmodule

FILE: test/tfn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_checker
// Watches the command, config and result ports of the triangle core, keeps
// its own copy of the offset registers, predicts the moved vertices and the
// unit face normal of every accepted triangle and compares each result word.
// ----------------------------------------------------------------------------
module tfn_checker
    import tfn_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [NVTX-1:0][COORD_W-1:0]  i_vtx,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [COORD_W-1:0]            i_cfg_data,
    input  logic                          i_valid,
    input  logic [NVTX-1:0][COORD_W-1:0]  i_moved,
    input  logic [NAXIS-1:0][NRM_W-1:0]   i_normal,
    output int                            o_fail_cnt,
    output int                            o_pending
);

    typedef struct {
        logic [NVTX-1:0][COORD_W-1:0] moved;
        logic [NAXIS-1:0][NRM_W-1:0]  normal;
    } t_face;

    logic [NAXIS-1:0][COORD_W-1:0] offset;
    t_face                         face_q[$];
    string                         vtx_name[NVTX] = '{"moved_a_x", "moved_a_y", "moved_a_z",
                                                      "moved_b_x", "moved_b_y", "moved_b_z",
                                                      "moved_c_x", "moved_c_y", "moved_c_z"};
    string                         nrm_name[NAXIS] = '{"normal_x", "normal_y", "normal_z"};

    function automatic logic [COORD_W-1:0] clamp_add(logic [COORD_W-1:0] a,
                                                     logic [COORD_W-1:0] b);
        logic signed [COORD_W+1:0] t;
        t = $signed(a);
        t = t + $signed(b);
        if (t > 34'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
        if (t < -34'sh0_8000_0000) return 32'h8000_0000;
        return t[COORD_W-1:0];
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_face predict_face(logic [NVTX-1:0][COORD_W-1:0] v);
        t_face                   f;
        logic signed [127:0]     e1[NAXIS];
        logic signed [127:0]     e2[NAXIS];
        logic signed [127:0]     cr[NAXIS];
        logic [127:0]            mg[NAXIS];
        longint unsigned         sc[NAXIS];
        longint unsigned         sum;
        longint unsigned         len;
        longint unsigned         q;
        int                      m;
        logic signed [127:0]     t;
        for (int i = 0; i < NVTX; i++) begin
            f.moved[i] = clamp_add(v[i], offset[i % NAXIS]);
        end
        for (int i = 0; i < NAXIS; i++) begin
            t = $signed(v[i]);
            e1[i] = $signed(v[NAXIS + i]);
            e2[i] = $signed(v[2*NAXIS + i]);
            e1[i] = e1[i] - t;
            e2[i] = e2[i] - t;
        end
        cr[0] = e2[1] * e1[2] - e1[1] * e2[2];
        cr[1] = e2[2] * e1[0] - e1[2] * e2[0];
        cr[2] = e2[0] * e1[1] - e1[0] * e2[1];
        m = 0;
        for (int i = 0; i < NAXIS; i++) begin
            mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
            for (int b = 0; b < 128; b++) begin
                if (mg[i][b] && b + 1 > m) m = b + 1;
            end
        end
        if (m == 0) begin
            f.normal = '0;
            return f;
        end
        sum = 0;
        for (int i = 0; i < NAXIS; i++) begin
            if (m < S_W) sc[i] = 64'(mg[i] << (S_W - m));
            else sc[i] = 64'(mg[i] >> (m - S_W));
            sum = sum + sc[i] * sc[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < NAXIS; i++) begin
            q = ((sc[i] << NORM_FRAC_BITS) + (len >> 1)) / len;
            if (q > (64'd1 << NORM_FRAC_BITS)) q = 64'd1 << NORM_FRAC_BITS;
            if (cr[i] < 0) q = -q;
            f.normal[i] = q[NRM_W-1:0];
        end
        return f;
    endfunction

    assign o_pending = face_q.size();

    always @(posedge i_clk) begin
        t_face exp_f;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            offset     <= '0;
            o_fail_cnt <= 0;
            face_q.delete();
        end else begin
            if (i_valid) begin
                if (face_q.size() == 0) begin
                    $error("result word with no triangle outstanding");
                    errs++;
                end else begin
                    exp_f = face_q.pop_front();
                    for (int i = 0; i < NVTX; i++) begin
                        if (i_moved[i] !== exp_f.moved[i]) begin
                            $error("%s expected %0d actual %0d", vtx_name[i],
                                   $signed(exp_f.moved[i]), $signed(i_moved[i]));
                            errs++;
                        end
                    end
                    for (int i = 0; i < NAXIS; i++) begin
                        if (i_normal[i] !== exp_f.normal[i]) begin
                            $error("%s expected %0d actual %0d", nrm_name[i],
                                   $signed(exp_f.normal[i]), $signed(i_normal[i]));
                            errs++;
                        end
                    end
                end
            end
            o_fail_cnt <= o_fail_cnt + errs;
            if (i_start && !i_busy) face_q.insert(face_q.size(), predict_face(i_vtx));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OFFSET_X: offset[0] <= i_cfg_data;
                    REG_OFFSET_Y: offset[1] <= i_cfg_data;
                    REG_OFFSET_Z: offset[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random triangles into the offset and face normal core
// in bursts, reprograms the offsets between phases, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
    import tfn_pkg::*;

    localparam int WATCH_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 70;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [NVTX-1:0][COORD_W-1:0] vtx;
    logic                         cfg_we;
    logic [CFG_IDX_W-1:0]         cfg_idx;
    logic [COORD_W-1:0]           cfg_data;
    logic                         valid;
    logic [NVTX-1:0][COORD_W-1:0] moved;
    logic [NAXIS-1:0][NRM_W-1:0]  normal;
    int                           fail_cnt;
    int                           pending;
    int                           idle_cycles;
    int                           burst_left;

    triangle_offset_and_face_normal_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_a_x       (vtx[0]),
        .i_a_y       (vtx[1]),
        .i_a_z       (vtx[2]),
        .i_b_x       (vtx[3]),
        .i_b_y       (vtx[4]),
        .i_b_z       (vtx[5]),
        .i_c_x       (vtx[6]),
        .i_c_y       (vtx[7]),
        .i_c_z       (vtx[8]),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_valid     (valid),
        .o_moved_a_x (moved[0]),
        .o_moved_a_y (moved[1]),
        .o_moved_a_z (moved[2]),
        .o_moved_b_x (moved[3]),
        .o_moved_b_y (moved[4]),
        .o_moved_b_z (moved[5]),
        .o_moved_c_x (moved[6]),
        .o_moved_c_y (moved[7]),
        .o_moved_c_z (moved[8]),
        .o_normal_x  (normal[0]),
        .o_normal_y  (normal[1]),
        .o_normal_z  (normal[2])
    );

    tfn_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_vtx      (vtx),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (valid),
        .i_moved    (moved),
        .i_normal   (normal),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCH_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return 32'h1;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] short_step();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    function automatic logic [NVTX-1:0][COORD_W-1:0] random_tri();
        logic [NVTX-1:0][COORD_W-1:0] t;
        logic [NAXIS-1:0][COORD_W-1:0] d;
        int k;
        int j;
        for (int i = 0; i < NVTX; i++) t[i] = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                for (int i = NAXIS; i < NVTX; i++) t[i] = t[i % NAXIS] + short_step();
            end
            6: begin
                k = $urandom_range(0, 40) - 20;
                j = $urandom_range(0, 40) - 20;
                for (int i = 0; i < NAXIS; i++) begin
                    d[i] = $signed($urandom) >>> $urandom_range(8, 31);
                    t[NAXIS + i]   = t[i] + d[i] * k;
                    t[2*NAXIS + i] = t[i] + d[i] * j;
                end
            end
            7: begin
                for (int i = 0; i < NVTX; i++) t[i] = pick_extreme();
            end
            8: begin
                for (int i = 0; i < NAXIS; i++) begin
                    if ($urandom_range(0, 1)) t[NAXIS + i] = t[i];
                    else t[2*NAXIS + i] = t[i];
                end
            end
            9: begin
                for (int i = 0; i < NVTX; i++) t[i] = $urandom_range(0, 128) - 64;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic push_tri(input logic [NVTX-1:0][COORD_W-1:0] t);
        int gap;
        start <= 1'b1;
        vtx   <= t;
        do @(posedge clk); while (busy);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 10);
        end
    endtask

    task automatic set_offsets(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                               input logic [COORD_W-1:0] oz);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= REG_OFFSET_X;
        cfg_data <= ox;
        @(negedge clk);
        cfg_idx <= REG_OFFSET_Y;
        cfg_data <= oy;
        @(negedge clk);
        cfg_idx <= REG_OFFSET_Z;
        cfg_data <= oz;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [NVTX-1:0][COORD_W-1:0] tri_of(logic [COORD_W-1:0] ax,
            logic [COORD_W-1:0] ay, logic [COORD_W-1:0] az, logic [COORD_W-1:0] bx,
            logic [COORD_W-1:0] by, logic [COORD_W-1:0] bz, logic [COORD_W-1:0] cx,
            logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz);
        return {cz, cy, cx, bz, by, bx, az, ay, ax};
    endfunction

    initial begin
        logic [COORD_W-1:0] mx;
        logic [COORD_W-1:0] mn;
        logic [COORD_W-1:0] one;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        one = 32'h0001_0000;
        rst_n = 1'b0;
        start = 1'b0;
        vtx = '0;
        cfg_we = 1'b0;
        cfg_idx = REG_OFFSET_X;
        cfg_data = '0;
        burst_left = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_tri(tri_of(0, 0, 0, one, 0, 0, 0, one, 0));
        push_tri(tri_of(0, 0, 0, 0, one, 0, 0, 0, one));
        push_tri(tri_of(0, 0, 0, 0, 0, one, one, 0, 0));
        push_tri(tri_of(0, 0, 0, 0, one, 0, one, 0, 0));
        push_tri(tri_of(5, 5, 5, 5, 5, 5, 7, 9, 1));
        push_tri(tri_of(5, 5, 5, 7, 9, 1, 5, 5, 5));
        push_tri(tri_of(1, 2, 3, 1, 2, 3, 1, 2, 3));
        push_tri(tri_of(0, 0, 0, 1, 2, 3, 2, 4, 6));
        push_tri(tri_of(mx, mx, mx, mn, mn, mn, mx, mn, 0));
        push_tri(tri_of(mn, mn, mn, mx, mn, mn, mn, mx, mn));
        push_tri(tri_of(mn, mx, mn, mx, mn, mx, mx, mx, mn));
        push_tri(tri_of(mx, mn, 0, 0, mx, mn, mn, 0, mx));
        push_tri(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
        push_tri(tri_of(0, 0, 0, 1, 1, 0, 1, 0, 1));
        push_tri(tri_of(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        set_offsets(mx, mx, mx);
        push_tri(tri_of(mx, 1, 0, mn, mx, 1, 0, mn, mx));
        push_tri(tri_of(mn, mn, mn, 0, 0, 0, mx, mx, mx));
        set_offsets(mn, mn, mn);
        push_tri(tri_of(mn, 32'hFFFF_FFFF, 0, mx, mn, 32'hFFFF_FFFF, 0, mx, mn));
        push_tri(tri_of(mx, mx, mx, 0, 0, 0, mn, mn, mn));

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: set_offsets($urandom, $urandom, $urandom);
                1: set_offsets(pick_extreme(), pick_extreme(), pick_extreme());
                2: set_offsets(short_step(), short_step(), short_step());
                default: set_offsets(0, 0, 0);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) push_tri(random_tri());
        end

        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (fail_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
